/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

/* hw/rtl/rlse_pkg.sv */
// ----------------------------------------------------------------------------
// rlse_pkg
// Types, constants and helpers of the LED strip pulse encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlse_pkg;

  localparam int unsigned TicksW   = 8;
  localparam int unsigned CountW   = 10;
  localparam int unsigned LevelInW = 16;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned ColourW  = 3 * LevelW;
  localparam int unsigned BitPosW  = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [BitPosW-1:0]  BitPosLast = BitPosW'(ColourW - 1);
  localparam logic [LevelW-1:0]   LevelMax   = 8'd255;

  localparam logic [TicksW-1:0] OneHighRst  = 8'd8;
  localparam logic [TicksW-1:0] ZeroHighRst = 8'd3;
  localparam logic [CountW-1:0] ResetSlotsRst = 10'd100;
  localparam logic [CountW-1:0] LedCountRst   = 10'd10;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SLOT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_TAIL = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_HIGH    = 2'd0,
    CFG_ZERO_HIGH   = 2'd1,
    CFG_RESET_SLOTS = 2'd2,
    CFG_LED_COUNT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TicksW-1:0] one_high_ticks;
    logic [TicksW-1:0] zero_high_ticks;
    logic [CountW-1:0] reset_slots;
    logic [CountW-1:0] led_count;
  } cfg_t;

  typedef struct packed {
    logic                req_type;
    logic [LevelInW-1:0] red_in;
    logic [LevelInW-1:0] green_in;
    logic [LevelInW-1:0] blue_in;
  } req_t;

  typedef struct packed {
    logic [TicksW-1:0] compare_ticks;
    logic              slot_active;
    logic              frame_end;
  } slot_t;

  function automatic logic [LevelW-1:0] clip_level(input logic [LevelInW-1:0] v);
    if (v > LevelInW'(LevelMax)) begin
      return LevelMax;
    end
    return v[LevelW-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rlse_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rlse_cfg_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlse_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rlse_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rlse_pkg::CfgDataW-1:0] cfg_wdata_i,
  output rlse_pkg::cfg_t                    cfg_o
);
  import rlse_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ONE_HIGH:    cfg_d.one_high_ticks  = cfg_wdata_i[TicksW-1:0];
        CFG_ZERO_HIGH:   cfg_d.zero_high_ticks = cfg_wdata_i[TicksW-1:0];
        CFG_RESET_SLOTS: cfg_d.reset_slots     = cfg_wdata_i[CountW-1:0];
        CFG_LED_COUNT:   cfg_d.led_count       = cfg_wdata_i[CountW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high_ticks  <= OneHighRst;
      cfg_q.zero_high_ticks <= ZeroHighRst;
      cfg_q.reset_slots     <= ResetSlotsRst;
      cfg_q.led_count       <= LedCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/rlse_slot_seq.sv */
// ----------------------------------------------------------------------------
// rlse_slot_seq
// Frame sequencer: holds the colour and frame position, computes one slot.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rlse_slot_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rlse_pkg::cfg_t  cfg_i,
  input  wire rlse_pkg::req_t  req_i,
  input  wire logic            fire_i,
  output rlse_pkg::slot_t      slot_o
);
  import rlse_pkg::*;

  logic [ColourW-1:0] colour_q, colour_d;
  phase_e             phase_q, phase_d;
  logic [CountW-1:0]  led_pos_q, led_pos_d;
  logic [BitPosW-1:0] bit_pos_q, bit_pos_d;
  logic [CountW-1:0]  tail_pos_q, tail_pos_d;

  logic [BitPosW-1:0] bit_sel;
  logic               data_bit;
  logic               led_done;
  logic               tail_done;
  phase_e             tail_entry;

  assign bit_sel   = BitPosLast - bit_pos_q;
  assign data_bit  = colour_q[bit_sel];
  assign led_done  = ({1'b0, led_pos_q} + 11'd1) >= {1'b0, cfg_i.led_count};
  assign tail_done = ({1'b0, tail_pos_q} + 11'd1) >= {1'b0, cfg_i.reset_slots};
  // An empty tail ends the frame right after the data part.
  assign tail_entry = (cfg_i.reset_slots == '0) ? PH_IDLE : PH_TAIL;

  always_comb begin
    colour_d   = colour_q;
    phase_d    = phase_q;
    led_pos_d  = led_pos_q;
    bit_pos_d  = bit_pos_q;
    tail_pos_d = tail_pos_q;
    slot_o     = '0;

    if (req_i.req_type == REQ_LOAD) begin
      colour_d   = {clip_level(req_i.green_in), clip_level(req_i.red_in),
                    clip_level(req_i.blue_in)};
      led_pos_d  = '0;
      bit_pos_d  = '0;
      tail_pos_d = '0;
      phase_d    = (cfg_i.led_count == '0) ? tail_entry : PH_DATA;
    end else begin
      case (phase_q)
        PH_DATA: begin
          slot_o.compare_ticks = data_bit ? cfg_i.one_high_ticks : cfg_i.zero_high_ticks;
          slot_o.slot_active   = 1'b1;
          if (bit_pos_q == BitPosLast) begin
            bit_pos_d = '0;
            if (led_done) begin
              led_pos_d        = '0;
              tail_pos_d       = '0;
              phase_d          = tail_entry;
              slot_o.frame_end = (tail_entry == PH_IDLE);
            end else begin
              led_pos_d = led_pos_q + 1'b1;
            end
          end else begin
            bit_pos_d = bit_pos_q + 1'b1;
          end
        end
        PH_TAIL: begin
          slot_o.slot_active = 1'b1;
          if (tail_done) begin
            slot_o.frame_end = 1'b1;
            tail_pos_d       = '0;
            phase_d          = PH_IDLE;
          end else begin
            tail_pos_d = tail_pos_q + 1'b1;
          end
        end
        default: begin
          slot_o = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q   <= '0;
      phase_q    <= PH_IDLE;
      led_pos_q  <= '0;
      bit_pos_q  <= '0;
      tail_pos_q <= '0;
    end else if (fire_i) begin
      colour_q   <= colour_d;
      phase_q    <= phase_d;
      led_pos_q  <= led_pos_d;
      bit_pos_q  <= bit_pos_d;
      tail_pos_q <= tail_pos_d;
    end
  end

  `ASSERT_AT(a_bit_pos_range, clk_i, rst_ni, bit_pos_q <= BitPosLast)
  `ASSERT_AT(a_idle_positions_clear, clk_i, rst_ni,
             (phase_q == PH_IDLE) |-> (led_pos_q == '0 && bit_pos_q == '0))
  `ASSERT_NEVER(a_end_without_active, clk_i, rst_ni,
                fire_i && slot_o.frame_end && !slot_o.slot_active)

endmodule

`default_nettype wire

/* hw/rtl/rgb_led_strip_pulse_encoder_core.sv */
// ----------------------------------------------------------------------------
// rgb_led_strip_pulse_encoder_core
// Pulse-width slot encoder for a serial RGB LED strip.
//
//   Channel   Direction  Carries
//   s_axis    in         load (colour) or slot request
//   m_axis    out        one slot per slot request, none per load
//   cfg       in         register writes, no read-back
//
// A request is taken into an input register, handled by the sequencer and its
// slot lands in the output register; one request per cycle is sustained while
// the output is taken. A full output register that is not taken holds
// back slot requests only; loads pass by it. Reset puts the block idle with
// the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_strip_pulse_encoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // red_in, green_in, blue_in
  input  wire logic [0:0]  s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // compare_ticks
  output logic [0:0]       m_axis_tuser,   // slot_active
  output logic             m_axis_tlast,   // frame_end
  input  wire logic        cfg_we_i,
  input  wire logic [rlse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rlse_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rlse_pkg::*;

  cfg_t  cfg;
  req_t  in_req_q;
  logic  in_valid_q;
  slot_t slot;
  slot_t out_slot_q;
  logic  out_valid_q;
  logic  advance;

  rlse_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Loads produce no slot, so they never wait on the output register.
  assign advance = in_valid_q &&
                   (in_req_q.req_type == REQ_LOAD || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q.req_type <= s_axis_tuser[0];
      in_req_q.red_in   <= s_axis_tdata[15:0];
      in_req_q.green_in <= s_axis_tdata[31:16];
      in_req_q.blue_in  <= s_axis_tdata[47:32];
    end
  end

  rlse_slot_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (in_req_q),
    .fire_i (advance),
    .slot_o (slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_req_q.req_type == REQ_SLOT) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_req_q.req_type == REQ_SLOT) begin
      out_slot_q <= slot;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_slot_q.compare_ticks;
  assign m_axis_tuser[0] = out_slot_q.slot_active;
  assign m_axis_tlast    = out_slot_q.frame_end;

endmodule

`default_nettype wire
